/* rtl/mts_pkg.sv */
`default_nettype none
package mts_pkg;

   localparam int CHANNELS = 4;
   localparam int QDEPTH   = 4;
   localparam int ADDR_W   = 12;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [1:0]          channel;
      logic [ADDR_W-1:0]   address;
      logic [7:0]          data;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHAN,
      ST_CMD,
      ST_OP,
      ST_ARG,
      ST_VOL2,
      ST_ACC,
      ST_LEN,
      ST_EMIT
   } eng_state_type;

   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_REPEAT = 8'hff;
   localparam logic [7:0] CH_T      = 8'h54;
   localparam logic [7:0] CH_V      = 8'h56;
   localparam logic [7:0] CH_O      = 8'h4f;
   localparam logic [7:0] CH_L      = 8'h4c;
   localparam logic [7:0] CH_R      = 8'h52;
   localparam logic [7:0] CH_GT     = 8'h3e;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_1      = 8'h31;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_A      = 8'h41;

   localparam logic [2:0] TEMPO_RST  = 3'd0;
   localparam logic [4:0] VOLUME_RST = 5'd15;
   localparam logic [2:0] OCTAVE_RST = 3'd3;
   localparam logic [3:0] LEN_RST    = 4'd5;
   localparam logic [7:0] REST_RST   = 8'd1;
   localparam logic [9:0] ATT_SILENT = 10'd15;
   localparam logic [4:0] VOL_FULL   = 5'd16;

   localparam logic [9:0] TONE_TAB [128] = '{
      10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,
      10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,
      10'h3f9,10'h3c0,10'h38a,10'h357,10'h000,10'h000,10'h000,10'h000,
      10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h000,10'h21b,
      10'h1fc,10'h1e0,10'h1c5,10'h1ac,10'h357,10'h327,10'h2fa,10'h2cf,
      10'h2a7,10'h281,10'h281,10'h25d,10'h23b,10'h21b,10'h000,10'h10e,
      10'h0ff,10'h0f0,10'h0e3,10'h0d6,10'h1ac,10'h193,10'h17d,10'h167,
      10'h154,10'h140,10'h140,10'h12e,10'h11d,10'h10e,10'h000,10'h086,
      10'h07f,10'h078,10'h071,10'h06b,10'h0d6,10'h0ca,10'h0be,10'h0b4,
      10'h0a9,10'h0a0,10'h0a0,10'h097,10'h08f,10'h086,10'h000,10'h044,
      10'h040,10'h03c,10'h039,10'h036,10'h06b,10'h065,10'h05f,10'h05a,
      10'h055,10'h050,10'h050,10'h04c,10'h048,10'h044,10'h000,10'h022,
      10'h020,10'h01e,10'h01d,10'h01b,10'h036,10'h032,10'h030,10'h02d,
      10'h02a,10'h028,10'h028,10'h026,10'h024,10'h022,10'h000,10'h011,
      10'h010,10'h00f,10'h00e,10'h00d,10'h01b,10'h019,10'h018,10'h016,
      10'h015,10'h014,10'h014,10'h013,10'h012,10'h011,10'h000,10'h000
   };

   localparam logic [7:0] LEN_TAB [128] = '{
      8'd1,8'd2,8'd3,8'd4,8'd6,8'd8,8'd12,8'd16,8'd20,8'd24,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
      8'd2,8'd4,8'd6,8'd8,8'd12,8'd16,8'd24,8'd32,8'd48,8'd64,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
      8'd3,8'd6,8'd9,8'd12,8'd18,8'd24,8'd36,8'd48,8'd72,8'd96,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
      8'd4,8'd8,8'd12,8'd16,8'd24,8'd32,8'd48,8'd64,8'd96,8'd128,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
      8'd5,8'd10,8'd15,8'd20,8'd30,8'd40,8'd60,8'd80,8'd120,8'd160,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
      8'd6,8'd12,8'd18,8'd24,8'd32,8'd48,8'd72,8'd96,8'd144,8'd192,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
      8'd7,8'd14,8'd21,8'd28,8'd42,8'd56,8'd84,8'd112,8'd168,8'd224,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
      8'd8,8'd16,8'd24,8'd32,8'd48,8'd64,8'd96,8'd128,8'd192,8'd0,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1
   };

endpackage
`default_nettype wire

/* rtl/mts_front.sv */
`default_nettype none
module mts_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  wire  [23:0]      req_tdata,   // op[1:0], channel[3:2], address[15:4], data_byte[23:16]
   output logic             cmd_valid,
   output mts_pkg::cmd_type cmd,
   input  wire              cmd_pop
);

   localparam int PW = $clog2(mts_pkg::QDEPTH);

   mts_pkg::cmd_type queue_ff [mts_pkg::QDEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   mts_pkg::cmd_type decoded;
   logic             push;
   logic             pop;

   // classify the incoming item
   always_comb begin
      decoded.channel = req_tdata[3:2];
      decoded.address = req_tdata[15:4];
      decoded.data    = req_tdata[23:16];
      case (req_tdata[1:0])
         2'd0:    decoded.kind = mts_pkg::CMD_WRITE;
         2'd1:    decoded.kind = mts_pkg::CMD_START;
         2'd2:    decoded.kind = mts_pkg::CMD_TICK;
         default: decoded.kind = mts_pkg::CMD_NONE;
      endcase
   end

   assign req_tready = (count_ff != (PW+1)'(mts_pkg::QDEPTH));
   assign push       = req_tvalid && req_tready && (decoded.kind != mts_pkg::CMD_NONE);
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

/* rtl/mts_engine.sv */
`default_nettype none
module mts_engine #(
   parameter int SCRIPT_DEPTH = 4096,
   parameter int MAX_PARSE    = 64
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              cmd_valid,
   input  mts_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   output logic [15:0]      rsp_tdata,   // voice[1:0], value[11:2], zero fill
   output logic             rsp_tuser,   // kind
   output logic             rsp_tlast
);

   localparam int AW = $clog2(SCRIPT_DEPTH);
   localparam int UW = $clog2(MAX_PARSE + 4);
   localparam int NC = mts_pkg::CHANNELS;

   logic [7:0]    mem [SCRIPT_DEPTH];
   logic [7:0]    rdata_ff;

   mts_pkg::eng_state_type state_ff, state_in;
   logic [1:0]    ch_ff, ch_in;
   logic          phase_ff, phase_in;
   logic [AW-1:0] p_ff, p_in;
   logic [UW-1:0] used_ff, used_in;
   logic [7:0]    arg_ff, arg_in;
   logic [6:0]    ix_ff, ix_in;

   logic [AW-1:0] head_ff [NC], head_in [NC];
   logic [AW-1:0] play_ff [NC], play_in [NC];
   logic [AW-1:0] pend_addr_ff [NC], pend_addr_in [NC];
   logic [NC-1:0] playing_ff, playing_in;
   logic [NC-1:0] pend_ff, pend_in;
   logic [NC-1:0] upd_ff, upd_in;
   logic [2:0]    tempo_ff [NC], tempo_in [NC];
   logic [4:0]    vol_ff [NC], vol_in [NC];
   logic [2:0]    oct_ff [NC], oct_in [NC];
   logic [3:0]    dlen_ff [NC], dlen_in [NC];
   logic [9:0]    tone_ff [NC], tone_in [NC];
   logic [7:0]    rest_ff [NC], rest_in [NC];

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_voice_ff, out_voice_in;
   logic          out_kind_ff, out_kind_in;
   logic [9:0]    out_value_ff, out_value_in;
   logic          out_last_ff, out_last_in;

   logic          mem_we;
   logic [AW-1:0] cmd_addr;
   logic [7:0]    rest_dec;
   logic          limit_hit;
   logic          is_digit;
   logic [3:0]    len_sel;
   logic [NC-1:0] emits;
   logic          later;
   logic          out_free;
   logic [9:0]    att;

   assign cmd_addr   = AW'(cmd.address);
   assign mem_we     = (state_ff == mts_pkg::ST_IDLE) && cmd_valid
                       && (cmd.kind == mts_pkg::CMD_WRITE);
   assign cmd_pop    = (state_ff == mts_pkg::ST_IDLE) && cmd_valid;
   assign rest_dec   = rest_ff[ch_ff] - 8'd1;
   assign limit_hit  = (used_ff >= UW'(MAX_PARSE));
   assign is_digit   = rdata_ff inside {[mts_pkg::CH_0:mts_pkg::CH_9]};
   assign len_sel    = is_digit ? 4'(rdata_ff - mts_pkg::CH_0) : dlen_ff[ch_ff];
   assign out_free   = !out_valid_ff || rsp_tready;
   assign att        = (vol_ff[ch_ff] <= mts_pkg::VOL_FULL)
                       ? 10'(mts_pkg::VOL_FULL - vol_ff[ch_ff]) : 10'd0;

   // voice 2 goes to channel 3 when both want it
   assign emits = {upd_ff[3], upd_ff[2] & ~upd_ff[3], upd_ff[1], upd_ff[0]};

   always_comb begin
      case (ch_ff)
         2'd0:    later = |emits[3:1];
         2'd1:    later = |emits[3:2];
         2'd2:    later = emits[3];
         default: later = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (cmd_valid && cmd.kind == mts_pkg::CMD_TICK) begin
               state_in = mts_pkg::ST_CHAN;
            end
         end
         mts_pkg::ST_CHAN: begin
            if (!pend_ff[ch_ff] && (!playing_ff[ch_ff] || rest_dec != 8'd0)) begin
               state_in = (ch_ff == 2'd3) ? mts_pkg::ST_EMIT : mts_pkg::ST_CHAN;
            end else if (!pend_ff[ch_ff]) begin
               state_in = mts_pkg::ST_CMD;
            end
         end
         mts_pkg::ST_CMD: begin
            if (limit_hit) begin
               state_in = (ch_ff == 2'd3) ? mts_pkg::ST_EMIT : mts_pkg::ST_CHAN;
            end else begin
               state_in = mts_pkg::ST_OP;
            end
         end
         mts_pkg::ST_OP: begin
            case (rdata_ff)
               mts_pkg::CH_END:
                  state_in = (ch_ff == 2'd3) ? mts_pkg::ST_EMIT : mts_pkg::ST_CHAN;
               mts_pkg::CH_REPEAT, mts_pkg::CH_GT, mts_pkg::CH_LT:
                  state_in = mts_pkg::ST_CMD;
               mts_pkg::CH_T, mts_pkg::CH_V, mts_pkg::CH_O, mts_pkg::CH_L:
                  state_in = mts_pkg::ST_ARG;
               mts_pkg::CH_R:
                  state_in = mts_pkg::ST_LEN;
               default:
                  state_in = mts_pkg::ST_ACC;
            endcase
         end
         mts_pkg::ST_ARG: begin
            state_in = (arg_ff == mts_pkg::CH_V) ? mts_pkg::ST_VOL2 : mts_pkg::ST_CMD;
         end
         mts_pkg::ST_VOL2: state_in = mts_pkg::ST_CMD;
         mts_pkg::ST_ACC:  state_in = mts_pkg::ST_LEN;
         mts_pkg::ST_LEN: begin
            state_in = (ch_ff == 2'd3) ? mts_pkg::ST_EMIT : mts_pkg::ST_CHAN;
         end
         mts_pkg::ST_EMIT: begin
            if (out_free && !(emits[ch_ff] && tone_ff[ch_ff] != 10'd0 && !phase_ff)
                && ch_ff == 2'd3) begin
               state_in = mts_pkg::ST_IDLE;
            end
         end
         default: state_in = mts_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      ch_in        = ch_ff;
      phase_in     = phase_ff;
      p_in         = p_ff;
      used_in      = used_ff;
      arg_in       = arg_ff;
      ix_in        = ix_ff;
      head_in      = head_ff;
      play_in      = play_ff;
      pend_addr_in = pend_addr_ff;
      playing_in   = playing_ff;
      pend_in      = pend_ff;
      upd_in       = upd_ff;
      tempo_in     = tempo_ff;
      vol_in       = vol_ff;
      oct_in       = oct_ff;
      dlen_in      = dlen_ff;
      tone_in      = tone_ff;
      rest_in      = rest_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_voice_in = out_voice_ff;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         mts_pkg::ST_IDLE: begin
            ch_in    = 2'd0;
            phase_in = 1'b0;
            if (cmd_valid && cmd.kind == mts_pkg::CMD_START) begin
               pend_addr_in[cmd.channel] = cmd_addr;
               pend_in[cmd.channel]      = 1'b1;
            end
         end
         mts_pkg::ST_CHAN: begin
            if (pend_ff[ch_ff]) begin
               head_in[ch_ff]    = pend_addr_ff[ch_ff];
               play_in[ch_ff]    = pend_addr_ff[ch_ff];
               pend_in[ch_ff]    = 1'b0;
               playing_in[ch_ff] = 1'b1;
               tempo_in[ch_ff]   = mts_pkg::TEMPO_RST;
               vol_in[ch_ff]     = mts_pkg::VOLUME_RST;
               oct_in[ch_ff]     = mts_pkg::OCTAVE_RST;
               dlen_in[ch_ff]    = mts_pkg::LEN_RST;
               tone_in[ch_ff]    = '0;
               rest_in[ch_ff]    = mts_pkg::REST_RST;
               upd_in[ch_ff]     = 1'b0;
            end else if (playing_ff[ch_ff]) begin
               rest_in[ch_ff] = rest_dec;
               if (rest_dec == 8'd0) begin
                  p_in    = play_ff[ch_ff];
                  used_in = '0;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         mts_pkg::ST_CMD: begin
            if (limit_hit) begin
               play_in[ch_ff] = p_ff;
               rest_in[ch_ff] = mts_pkg::REST_RST;
               ch_in          = ch_ff + 2'd1;
            end
         end
         mts_pkg::ST_OP: begin
            p_in    = p_ff + 1'b1;
            used_in = used_ff + 1'b1;
            arg_in  = rdata_ff;
            ix_in   = {oct_ff[ch_ff], 4'd0} + {6'(rdata_ff - mts_pkg::CH_A), 1'b0};
            case (rdata_ff)
               mts_pkg::CH_END: begin
                  head_in[ch_ff]    = '0;
                  play_in[ch_ff]    = '0;
                  playing_in[ch_ff] = 1'b0;
                  tone_in[ch_ff]    = '0;
                  upd_in[ch_ff]     = 1'b1;
                  ch_in             = ch_ff + 2'd1;
               end
               mts_pkg::CH_REPEAT: begin
                  p_in           = head_ff[ch_ff];
                  play_in[ch_ff] = head_ff[ch_ff];
               end
               mts_pkg::CH_GT: oct_in[ch_ff] = oct_ff[ch_ff] - 3'd1;
               mts_pkg::CH_LT: oct_in[ch_ff] = oct_ff[ch_ff] + 3'd1;
               mts_pkg::CH_R:  tone_in[ch_ff] = '0;
               default: ;
            endcase
         end
         mts_pkg::ST_ARG: begin
            p_in    = p_ff + 1'b1;
            used_in = used_ff + 1'b1;
            case (arg_ff)
               mts_pkg::CH_T: tempo_in[ch_ff] = 3'(rdata_ff - mts_pkg::CH_1);
               mts_pkg::CH_O: oct_in[ch_ff]   = 3'(rdata_ff - mts_pkg::CH_1);
               mts_pkg::CH_L: dlen_in[ch_ff]  = 4'(rdata_ff - mts_pkg::CH_0);
               default:       vol_in[ch_ff]   = 5'(rdata_ff - mts_pkg::CH_0);
            endcase
         end
         mts_pkg::ST_VOL2: begin
            if (is_digit) begin
               vol_in[ch_ff] = 5'(8'd10 + rdata_ff - mts_pkg::CH_0);
               p_in          = p_ff + 1'b1;
               used_in       = used_ff + 1'b1;
            end
         end
         mts_pkg::ST_ACC: begin
            if (rdata_ff == mts_pkg::CH_PLUS) begin
               p_in           = p_ff + 1'b1;
               used_in        = used_ff + 1'b1;
               tone_in[ch_ff] = mts_pkg::TONE_TAB[ix_ff + 7'd1];
            end else if (rdata_ff == mts_pkg::CH_MINUS) begin
               p_in           = p_ff + 1'b1;
               used_in        = used_ff + 1'b1;
               tone_in[ch_ff] = mts_pkg::TONE_TAB[ix_ff - 7'd1];
            end else begin
               tone_in[ch_ff] = mts_pkg::TONE_TAB[ix_ff];
            end
         end
         mts_pkg::ST_LEN: begin
            if (is_digit) begin
               p_in    = p_ff + 1'b1;
               used_in = used_ff + 1'b1;
            end
            rest_in[ch_ff] = mts_pkg::LEN_TAB[{tempo_ff[ch_ff], len_sel}];
            upd_in[ch_ff]  = 1'b1;
            play_in[ch_ff] = is_digit ? p_ff + 1'b1 : p_ff;
            ch_in          = ch_ff + 2'd1;
         end
         mts_pkg::ST_EMIT: begin
            if (out_free) begin
               if (emits[ch_ff]) begin
                  out_valid_in = 1'b1;
                  out_voice_in = (ch_ff == 2'd3) ? 2'd2 : ch_ff;
                  if (tone_ff[ch_ff] != 10'd0 && !phase_ff) begin
                     out_kind_in  = 1'b0;
                     out_value_in = att;
                     out_last_in  = 1'b0;
                     phase_in     = 1'b1;
                  end else if (tone_ff[ch_ff] != 10'd0) begin
                     out_kind_in  = 1'b1;
                     out_value_in = tone_ff[ch_ff];
                     out_last_in  = !later;
                     phase_in     = 1'b0;
                     ch_in        = ch_ff + 2'd1;
                  end else begin
                     out_kind_in  = 1'b0;
                     out_value_in = mts_pkg::ATT_SILENT;
                     out_last_in  = !later;
                     ch_in        = ch_ff + 2'd1;
                     if (!playing_ff[ch_ff]) begin
                        upd_in[ch_ff] = 1'b0;
                     end
                  end
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mts_pkg::ST_IDLE;
         ch_ff        <= '0;
         phase_ff     <= 1'b0;
         used_ff      <= '0;
         playing_ff   <= '0;
         pend_ff      <= '0;
         upd_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NC; i++) begin
            head_ff[i]      <= '0;
            play_ff[i]      <= '0;
            pend_addr_ff[i] <= '0;
            tempo_ff[i]     <= mts_pkg::TEMPO_RST;
            vol_ff[i]       <= mts_pkg::VOLUME_RST;
            oct_ff[i]       <= mts_pkg::OCTAVE_RST;
            dlen_ff[i]      <= mts_pkg::LEN_RST;
            tone_ff[i]      <= '0;
            rest_ff[i]      <= mts_pkg::REST_RST;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         phase_ff     <= phase_in;
         used_ff      <= used_in;
         playing_ff   <= playing_in;
         pend_ff      <= pend_in;
         upd_ff       <= upd_in;
         out_valid_ff <= out_valid_in;
         head_ff      <= head_in;
         play_ff      <= play_in;
         pend_addr_ff <= pend_addr_in;
         tempo_ff     <= tempo_in;
         vol_ff       <= vol_in;
         oct_ff       <= oct_in;
         dlen_ff      <= dlen_in;
         tone_ff      <= tone_in;
         rest_ff      <= rest_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      arg_ff       <= arg_in;
      ix_ff        <= ix_in;
      out_voice_ff <= out_voice_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   // read follows the next pointer so the byte at p_ff is always at hand
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd_addr] <= cmd.data;
      end
      rdata_ff <= mem[p_in];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_value_ff, out_voice_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

/* rtl/mml_tone_sequencer_top.sv */
// Four-channel tone sequencer driving three sound-chip voices.
// req channel: write script bytes (op 0), queue a channel start (op 1),
// or tick (op 2). Items enter a four-deep command queue, so the sender
// keeps going while the parser works on an earlier tick.
// rsp channel: attenuation and tone period writes; tlast marks the final
// write of a tick. A tick with nothing to update gives no items.
// The engine takes a write or start straight from its idle state. A tick
// visits each channel in turn, parses script bytes (one registered read
// of the script memory per byte), then hands out results; the parse limit
// of MAX_PARSE bytes per channel, checked before each command, bounds it.
// Results of a tick come out only once all four channels are parsed.
// When the receiver stalls, the result register holds and the engine
// waits; the queue keeps taking items until it is full.
// Reset (synchronous, active high) clears every channel and empties the
// queue; the script memory keeps its contents and has no clearing pass.
`default_nettype none
module mml_tone_sequencer_top #(
   parameter int SCRIPT_DEPTH = 4096,
   parameter int MAX_PARSE    = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // op[1:0], channel[3:2], address[15:4], data_byte[23:16]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // voice[1:0], value[11:2], zero fill
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast
);

   logic             cmd_valid;
   logic             cmd_pop;
   mts_pkg::cmd_type cmd;

   mts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   mts_engine #(
      .SCRIPT_DEPTH (SCRIPT_DEPTH),
      .MAX_PARSE    (MAX_PARSE)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
   import mts_pkg::*;

   localparam int PARSE_LIMIT = 64;
   localparam int NUM_SLOTS   = 16;

   typedef struct packed {
      logic [1:0] voice;
      logic       kind;
      logic [9:0] value;
      logic       last;
   } psg_write_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // op[1:0], channel[3:2], address[15:4], data_byte[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // voice[1:0], value[11:2], zero fill
   logic        rsp_tuser;   // kind
   logic        rsp_tlast;

   mml_tone_sequencer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // sequencer image kept alongside the block
   logic [7:0]  script_img [4096];
   logic [11:0] chan_head  [4];
   logic [11:0] chan_pos   [4];
   logic        chan_on    [4];
   logic [11:0] start_addr [4];
   logic        start_pend [4];
   logic [2:0]  chan_tempo [4];
   logic [4:0]  chan_vol   [4];
   logic [2:0]  chan_oct   [4];
   logic [3:0]  chan_dlen  [4];
   logic [9:0]  chan_tone  [4];
   logic [7:0]  chan_rest  [4];
   logic        chan_upd   [4];

   psg_write_t  expected_writes [$];

   // script slots: 256 bytes each, scripts below offset 192, scratch above
   logic        slot_valid [NUM_SLOTS];
   logic [11:0] slot_start [NUM_SLOTS];
   int          slot_len   [NUM_SLOTS];
   logic [7:0]  script_buf [$];

   int send_idle;
   int rsp_stall;
   int hold_left;
   int mismatches;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      #20_000_000;
      $display("mml_tone_sequencer_top verification failed");
      $finish;
   end

   function automatic void clear_channel(int c);
      chan_tempo[c] = TEMPO_RST;
      chan_vol[c]   = VOLUME_RST;
      chan_oct[c]   = OCTAVE_RST;
      chan_dlen[c]  = LEN_RST;
      chan_tone[c]  = '0;
      chan_rest[c]  = REST_RST;
      chan_upd[c]   = 1'b0;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= CH_0 && b <= CH_9;
   endfunction

   function automatic void parse_channel(int c);
      logic [11:0] p;
      int          used;
      logic [7:0]  b;
      logic [7:0]  a;
      int          ix;
      p = chan_pos[c];
      used = 0;
      forever begin
         if (used >= PARSE_LIMIT) begin
            chan_pos[c]  = p;
            chan_rest[c] = 8'd1;
            return;
         end
         b = script_img[p];
         p++;
         used++;
         if (b == CH_END) begin
            chan_head[c] = '0;
            chan_pos[c]  = '0;
            chan_on[c]   = 1'b0;
            chan_tone[c] = '0;
            chan_upd[c]  = 1'b1;
            return;
         end else if (b == CH_REPEAT) begin
            p = chan_head[c];
            chan_pos[c] = p;
            continue;
         end else if (b == CH_T) begin
            chan_tempo[c] = 3'(script_img[p] - CH_1);
            p++;
            used++;
            continue;
         end else if (b == CH_V) begin
            chan_vol[c] = 5'(script_img[p] - CH_0);
            p++;
            used++;
            a = script_img[p];
            if (is_digit(a)) begin
               chan_vol[c] = 5'(8'd10 + a - CH_0);
               p++;
               used++;
            end
            continue;
         end else if (b == CH_O) begin
            chan_oct[c] = 3'(script_img[p] - CH_1);
            p++;
            used++;
            continue;
         end else if (b == CH_GT) begin
            chan_oct[c] = chan_oct[c] - 3'd1;
            continue;
         end else if (b == CH_LT) begin
            chan_oct[c] = chan_oct[c] + 3'd1;
            continue;
         end else if (b == CH_L) begin
            chan_dlen[c] = 4'(script_img[p] - CH_0);
            p++;
            used++;
            continue;
         end else if (b == CH_R) begin
            chan_tone[c] = '0;
         end else begin
            ix = int'(chan_oct[c]) * 16 + (int'(b) - int'(CH_A)) * 2;
            a = script_img[p];
            if (a == CH_PLUS) begin
               p++;
               used++;
               ix++;
            end else if (a == CH_MINUS) begin
               p++;
               used++;
               ix--;
            end
            chan_tone[c] = TONE_TAB[ix & 127];
         end
         // optional length digit after a note or rest
         a = script_img[p];
         if (is_digit(a)) begin
            a = a - CH_0;
            p++;
            used++;
         end else begin
            a = 8'(chan_dlen[c]);
         end
         chan_rest[c] = LEN_TAB[((int'(chan_tempo[c]) << 4) + int'(a)) & 127];
         chan_upd[c]  = 1'b1;
         chan_pos[c]  = p;
         return;
      end
   endfunction

   function automatic void post_voice(int c, logic [1:0] v);
      logic [9:0] att;
      if (!chan_upd[c]) return;
      if (chan_tone[c] != 0) begin
         att = (chan_vol[c] <= VOL_FULL) ? 10'(VOL_FULL - chan_vol[c]) : 10'd0;
         expected_writes.push_back('{voice: v, kind: 1'b0, value: att, last: 1'b0});
         expected_writes.push_back('{voice: v, kind: 1'b1, value: chan_tone[c], last: 1'b0});
      end else begin
         expected_writes.push_back('{voice: v, kind: 1'b0, value: ATT_SILENT, last: 1'b0});
         if (!chan_on[c]) chan_upd[c] = 1'b0;
      end
   endfunction

   function automatic void apply_item(cmd_kind_type op, logic [1:0] ch, logic [11:0] addr,
                                      logic [7:0] dat);
      int before_n;
      case (op)
         CMD_WRITE: script_img[addr] = dat;
         CMD_START: begin
            start_addr[ch] = addr;
            start_pend[ch] = 1'b1;
         end
         CMD_TICK: begin
            before_n = expected_writes.size();
            for (int c = 0; c < 4; c++) begin
               if (start_pend[c]) begin
                  chan_head[c]  = start_addr[c];
                  chan_pos[c]   = start_addr[c];
                  start_pend[c] = 1'b0;
                  chan_on[c]    = 1'b1;
                  clear_channel(c);
               end
               if (!chan_on[c]) continue;
               chan_rest[c] = chan_rest[c] - 8'd1;
               if (chan_rest[c] != 0) continue;
               parse_channel(c);
            end
            post_voice(0, 2'd0);
            post_voice(1, 2'd1);
            // channel 3 owns voice 2 whenever it has something to say
            if (!chan_upd[3]) post_voice(2, 2'd2);
            post_voice(3, 2'd2);
            if (expected_writes.size() > before_n)
               expected_writes[expected_writes.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(cmd_kind_type op, logic [1:0] ch, logic [11:0] addr,
                            logic [7:0] dat);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dat, addr, ch, op};
      do @(posedge clock); while (!req_tready);
      apply_item(op, ch, addr, dat);
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, 2'($urandom_range(3)), 12'($urandom_range(4095)),
                8'($urandom_range(255)));
   endtask

   task automatic send_start(logic [1:0] ch, logic [11:0] addr);
      send_item(CMD_START, ch, addr, 8'($urandom_range(255)));
   endtask

   // writes script_buf at base and records it as the slot's script
   task automatic load_script(logic [11:0] base);
      int s;
      s = int'(base[11:8]);
      slot_valid[s] = 1'b0;
      foreach (script_buf[i])
         send_item(CMD_WRITE, 2'($urandom_range(3)), base + 12'(i), script_buf[i]);
      slot_start[s] = base;
      slot_len[s]   = script_buf.size();
      slot_valid[s] = 1'b1;
   endtask

   function automatic logic slot_busy(int s);
      for (int c = 0; c < 4; c++) begin
         if (start_pend[c] && int'(start_addr[c][11:8]) == s) return 1'b1;
         if (chan_on[c] && int'(chan_head[c][11:8]) == s) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int pick_free_slot();
      int s;
      do s = $urandom_range(NUM_SLOTS - 1); while (slot_busy(s));
      return s;
   endfunction

   function automatic logic [7:0] pick_arg(logic [7:0] lo, int span);
      if ($urandom_range(7) == 0) return 8'($urandom_range(255));
      return lo + 8'($urandom_range(span));
   endfunction

   // random MML text, always closed by two end or repeat codes so that
   // argument and look-ahead reads stay inside written bytes
   function automatic void build_script();
      int target;
      logic [7:0] term;
      target = $urandom_range(1, 50);
      script_buf = {};
      while (script_buf.size() < target) begin
         case ($urandom_range(9))
            0: begin
               script_buf.push_back(CH_T);
               script_buf.push_back(pick_arg(CH_1, 1));
            end
            1: begin
               script_buf.push_back(CH_V);
               script_buf.push_back(pick_arg(CH_0, 9));
               if ($urandom_range(2) == 0) script_buf.push_back(pick_arg(CH_0, 9));
            end
            2: begin
               script_buf.push_back(CH_O);
               script_buf.push_back(pick_arg(CH_1, 7));
            end
            3: script_buf.push_back($urandom_range(1) ? CH_GT : CH_LT);
            4: begin
               script_buf.push_back(CH_L);
               script_buf.push_back(pick_arg(CH_0, 4));
            end
            5: begin
               script_buf.push_back(CH_R);
               if ($urandom_range(1)) script_buf.push_back(pick_arg(CH_0, 3));
            end
            default: begin
               script_buf.push_back(pick_arg(CH_A, 6));
               case ($urandom_range(3))
                  0: script_buf.push_back(CH_PLUS);
                  1: script_buf.push_back(CH_MINUS);
                  default: ;
               endcase
               if ($urandom_range(2) != 0) script_buf.push_back(pick_arg(CH_0, 3));
            end
         endcase
      end
      term = $urandom_range(1) ? CH_END : CH_REPEAT;
      script_buf.push_back(term);
      script_buf.push_back(term);
   endfunction

   // result side: random stalls, or a long hold-off when asked
   initial begin
      psg_write_t got;
      psg_write_t want;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{voice: rsp_tdata[1:0], kind: rsp_tuser, value: rsp_tdata[11:2],
                    last: rsp_tlast};
            if (expected_writes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected write: voice %0d kind %0d value %0d last %0d",
                           got.voice, got.kind, got.value, got.last);
            end else begin
               want = expected_writes.pop_front();
               if (got.voice !== want.voice || got.kind !== want.kind ||
                   got.value !== want.value || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("write mismatch: expected v%0d k%0d val%0d l%0d, got v%0d k%0d val%0d l%0d",
                              want.voice, want.kind, want.value, want.last,
                              got.voice, got.kind, got.value, got.last);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall);
         end
      end
   end

   task automatic test_special_cases();
      send_idle = 0;
      rsp_stall = 0;
      // loud volume, top octave, sharp note near the top of the table, start at address 0
      script_buf = '{CH_V, CH_1, CH_9, CH_O, CH_0 + 8'd8, CH_A + 8'd6, CH_PLUS, CH_1,
                     CH_END, CH_END};
      load_script(12'h000);
      // bare repeat at the head: hits the per-tick parse limit
      script_buf = '{CH_REPEAT, CH_REPEAT};
      load_script(12'h100);
      // lower-case letter: note index wraps
      script_buf = '{8'h7a, CH_1, CH_END, CH_END};
      load_script(12'h200);
      send_start(2'd3, 12'h000);
      send_start(2'd2, 12'h200);
      send_start(2'd1, 12'h100);
      send_item(CMD_NONE, 2'd3, 12'hfff, 8'hff);
      repeat (3) send_tick();
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
      int sent;
      int pick;
      int s;
      send_idle = idle_pct;
      rsp_stall = stall_pct;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_tick();
            sent++;
         end else if (pick < 60) begin
            do s = $urandom_range(NUM_SLOTS - 1); while (!slot_valid[s]);
            send_start(2'($urandom_range(3)),
                       slot_start[s] + 12'($urandom_range(slot_len[s] - 1)));
            sent++;
         end else if (pick < 72) begin
            s = pick_free_slot();
            build_script();
            load_script(12'(s * 256 + $urandom_range(130)));
            sent += script_buf.size();
         end else if (pick < 95) begin
            send_item(CMD_WRITE, 2'($urandom_range(3)),
                      12'($urandom_range(NUM_SLOTS - 1) * 256 + $urandom_range(192, 255)),
                      8'($urandom_range(255)));
            sent++;
         end else begin
            send_item(CMD_NONE, 2'($urandom_range(3)), 12'($urandom_range(4095)),
                      8'($urandom_range(255)));
         end
      end
   endtask

   task automatic test_long_stall();
      int s;
      send_idle = 0;
      rsp_stall = 0;
      s = pick_free_slot();
      // one note every tick on all channels, so every tick gives results
      script_buf = '{CH_V, CH_0 + 8'd8, CH_A, CH_0, CH_REPEAT, CH_REPEAT};
      load_script(12'(s * 256));
      for (int c = 0; c < 4; c++) send_start(2'(c), 12'(s * 256));
      hold_left = 400;
      repeat (30) send_tick();
   endtask

   initial begin
      mismatches = 0;
      hold_left  = 0;
      send_idle  = 0;
      rsp_stall  = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      for (int s = 0; s < NUM_SLOTS; s++) slot_valid[s] = 1'b0;
      for (int c = 0; c < 4; c++) begin
         chan_head[c]  = '0;
         chan_pos[c]   = '0;
         chan_on[c]    = 1'b0;
         start_addr[c] = '0;
         start_pend[c] = 1'b0;
         clear_channel(c);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      test_random_traffic(0, 0, 100);
      test_random_traffic(82, 0, 100);
      test_long_stall();
      test_random_traffic(0, 82, 100);
      test_random_traffic(14, 14, 100);

      req_tvalid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      if (mismatches == 0 && expected_writes.size() == 0)
         $display("mml_tone_sequencer_top verification clean");
      else
         $display("mml_tone_sequencer_top verification failed");
      $finish;
   end

endmodule

/* files.f */
rtl/mts_pkg.sv
rtl/mts_front.sv
rtl/mts_engine.sv
rtl/mml_tone_sequencer_top.sv
tb/tb_top.sv
